### design/qps_pkg.sv
// qps_pkg: shared types for the ready queue priority select block
// operation codes, result status codes, controller states and the
// command and status structs between controller and datapath
`default_nettype none

package qps_pkg;

    localparam int unsigned FUNC_W = 3;
    localparam int unsigned ID_W   = 8;
    localparam int unsigned PRI_W  = 8;
    localparam int unsigned STAT_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQUEUE = 3'd0,
        FN_DEQUEUE = 3'd1,
        FN_REMOVE  = 3'd2,
        FN_PEEK    = 3'd3,
        FN_TAKE    = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    in_ready;
        logic    enq;
        logic    scan_init;
        logic    scan_step;
        logic    shift_init;
        logic    shift_step;
        logic    pop_head;
        logic    drop_tail;
        logic    res_load;
        status_t res_status;
        logic    res_best;
        logic    publish;
    } cmd_t;

    typedef struct packed {
        logic  in_fire;
        func_t op;
        logic  empty;
        logic  full;
        logic  scan_done;
        logic  found;
        logic  shift_done;
        logic  out_busy;
    } sts_t;

endpackage

`default_nettype wire

### design/qps_if.sv
// qps_req_if and qps_rsp_if: valid/ready channels for operation and result items
// depends on qps_pkg for field widths
`default_nettype none

interface qps_req_if;
    import qps_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   task_id;
    logic [PRI_W-1:0]  task_priority;

    modport source (output valid, output func, output task_id, output task_priority,
                    input ready);
    modport sink   (input valid, input func, input task_id, input task_priority,
                    output ready);
endinterface

interface qps_rsp_if #(
    parameter int CNT_W = 5
);
    import qps_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic [PRI_W-1:0]  out_priority;
    logic              is_empty;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, output status, output out_id, output out_priority,
                    output is_empty, output entry_count, input ready);
    modport sink   (input valid, input status, input out_id, input out_priority,
                    input is_empty, input entry_count, output ready);
endinterface

`default_nettype wire

### design/qps_ctrl.sv
// qps_ctrl: operation sequencer for the ready queue
// depends on qps_pkg for state, command and status types
`default_nettype none

module qps_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  qps_pkg::sts_t     sts,
    output qps_pkg::cmd_t     cmd
);
    import qps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sts.in_fire)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (sts.op)
                    FN_DEQUEUE, FN_PEEK, FN_TAKE:
                    begin
                        state_next = sts.empty ? S_FINISH : S_SCAN;
                    end
                    FN_REMOVE:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    case (sts.op)
                        FN_REMOVE:
                        begin
                            state_next = sts.found ? S_SHIFT : S_FINISH;
                        end
                        FN_TAKE:
                        begin
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            S_START:
            begin
                case (sts.op)
                    FN_ENQUEUE:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = sts.full ? ST_FULL : ST_DONE;
                        cmd.enq        = !sts.full;
                    end
                    FN_DEQUEUE, FN_PEEK, FN_TAKE:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_MISS;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                        end
                    end
                    FN_REMOVE:
                    begin
                        cmd.scan_init = 1'b1;
                    end
                    default:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.res_load = 1'b1;
                    case (sts.op)
                        FN_DEQUEUE:
                        begin
                            cmd.res_status = ST_DONE;
                            cmd.res_best   = 1'b1;
                            cmd.pop_head   = 1'b1;
                        end
                        FN_TAKE:
                        begin
                            cmd.res_status = ST_DONE;
                            cmd.res_best   = 1'b1;
                            cmd.shift_init = 1'b1;
                        end
                        FN_REMOVE:
                        begin
                            cmd.res_status = sts.found ? ST_DONE : ST_MISS;
                            cmd.shift_init = sts.found;
                        end
                        default:
                        begin
                            cmd.res_status = ST_DONE;
                            cmd.res_best   = 1'b1;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                cmd.drop_tail  = sts.shift_done;
            end
            S_FINISH:
            begin
                cmd.publish = !sts.out_busy;
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/qps_dpath.sv
// qps_dpath: entry store, head/tail/count registers, scan and compaction
// pointers, result and output registers; depends on qps_pkg and qps_if
`default_nettype none

module qps_dpath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  qps_pkg::cmd_t   cmd,
    output qps_pkg::sts_t   sts,
    qps_req_if.sink         req,
    qps_rsp_if.source       rsp
);
    import qps_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = ID_W + PRI_W;
    localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

    logic [ENT_W-1:0] store [QUEUE_DEPTH];

    func_t            op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [PRI_W-1:0] pri_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] rd_pos_reg;
    logic             rd_vld_reg, rd_vld_next;
    logic [ENT_W-1:0] rd_data_reg;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] best_pos_reg, best_pos_next;
    logic [ID_W-1:0]  best_id_reg, best_id_next;
    logic [PRI_W-1:0] best_pri_reg, best_pri_next;

    status_t          res_status_reg;
    logic [ID_W-1:0]  res_id_reg;
    logic [PRI_W-1:0] res_pri_reg;

    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic [PRI_W-1:0] out_pri_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic             in_fire;
    logic [CNT_W-1:0] limit;
    logic             issue;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic [ID_W-1:0]  rd_id;
    logic [PRI_W-1:0] rd_pri;
    logic             id_match;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] pos);
        logic [CNT_W:0] sum;
        sum = {1'b0, CNT_W'(head)} + {1'b0, pos};
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign in_fire   = req.valid && cmd.in_ready;
    assign req.ready = cmd.in_ready;

    assign rd_id    = rd_data_reg[ENT_W-1:PRI_W];
    assign rd_pri   = rd_data_reg[PRI_W-1:0];
    assign limit    = (op_reg == FN_DEQUEUE) ? CNT_W'(1) : count_reg;
    assign id_match = rd_vld_reg && (op_reg == FN_REMOVE) && (rd_id == id_reg) && !found_reg;
    assign rd_addr  = slot_of(head_reg, pos_reg);

    always_comb
    begin
        issue = 1'b0;
        if (cmd.scan_step)
        begin
            issue = (pos_reg < limit) && !found_reg;
        end
        else if (cmd.shift_step)
        begin
            issue = pos_reg < count_reg;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = tail_reg;
        wr_data = {id_reg, pri_reg};
        if (cmd.enq)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.shift_step && rd_vld_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_reg, rd_pos_reg - CNT_W'(1));
            wr_data = rd_data_reg;
        end
    end

    // entry store with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= wr_data;
        end
        rd_data_reg <= store[rd_addr];
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        rd_vld_next   = 1'b0;
        found_next    = found_reg;
        best_pos_next = best_pos_reg;
        best_id_next  = best_id_reg;
        best_pri_next = best_pri_reg;

        if (cmd.enq)
        begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
            count_next = count_reg + CNT_W'(1);
        end

        if (cmd.scan_init)
        begin
            pos_next   = '0;
            found_next = 1'b0;
        end

        if (cmd.scan_step || cmd.shift_step)
        begin
            rd_vld_next = issue;
            if (issue)
            begin
                pos_next = pos_reg + CNT_W'(1);
            end
        end

        if (cmd.scan_step && rd_vld_reg)
        begin
            if (id_match)
            begin
                found_next    = 1'b1;
                best_pos_next = rd_pos_reg;
            end
            if ((op_reg != FN_REMOVE) && ((rd_pos_reg == '0) || (rd_pri < best_pri_reg)))
            begin
                best_pos_next = rd_pos_reg;
                best_id_next  = rd_id;
                best_pri_next = rd_pri;
            end
        end

        if (cmd.shift_init)
        begin
            pos_next = best_pos_next + CNT_W'(1);
        end

        if (cmd.pop_head)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
            count_next = count_reg - CNT_W'(1);
        end

        if (cmd.drop_tail)
        begin
            tail_next  = (tail_reg == '0) ? LAST_IDX : tail_reg - IDX_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            rd_vld_reg <= rd_vld_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg   <= pos_reg;
        best_pos_reg <= best_pos_next;
        best_id_reg  <= best_id_next;
        best_pri_reg <= best_pri_next;
        if (in_fire)
        begin
            op_reg  <= func_t'(req.func);
            id_reg  <= req.task_id;
            pri_reg <= req.task_priority;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_id_reg     <= cmd.res_best ? best_id_next : '0;
            res_pri_reg    <= cmd.res_best ? best_pri_next : '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_pri_reg    <= res_pri_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_id       = out_id_reg;
    assign rsp.out_priority = out_pri_reg;
    assign rsp.entry_count  = out_count_reg;
    assign rsp.is_empty     = (out_count_reg == '0);

    assign sts.in_fire    = in_fire;
    assign sts.op         = op_reg;
    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (count_reg == DEPTH_CNT);
    assign sts.scan_done  = ((pos_reg == limit) || found_reg) && !rd_vld_reg;
    assign sts.found      = found_reg;
    assign sts.shift_done = (pos_reg == count_reg) && !rd_vld_reg;
    assign sts.out_busy   = out_valid_reg && !rsp.ready;

endmodule

`default_nettype wire

### design/ready_queue_priority_select_core.sv
// ready queue with most-urgent extraction: one item in flight, the next item is accepted
// the cycle after a result enters the output register; enqueue, unused codes and any read
// of an empty queue go from start straight to finish; dequeue reads the head entry; peek and
// remove miss sweep all n entries through one registered read port; take and remove hit
// sweep to find position p, then compact the entries behind p one slot toward the head
// reset empties the queue and the output register; store contents stay undefined
`default_nettype none

module ready_queue_priority_select_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    qps_req_if.sink   req,
    qps_rsp_if.source rsp
);
    import qps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    qps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    qps_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

### sim/qps_result_checker.sv
// qps_result_checker: watches the operation and result channels of the ready queue,
// predicts each result from its own copy of the queue and compares field by field
// depends on qps_pkg and the qps_req_if / qps_rsp_if interfaces
`default_nettype none

module qps_result_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    qps_req_if        req,
    qps_rsp_if        rsp,
    output int        fail_count,
    output int        pending
);
    import qps_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic             empty;
        logic [CNT_W-1:0] count;
    } queue_result_t;

    logic [ID_W-1:0]  id_store  [QUEUE_DEPTH];
    logic [PRI_W-1:0] pri_store [QUEUE_DEPTH];
    int               head_pos;
    int               tail_pos;
    int               held;
    queue_result_t    expected_q[$];
    int               errors;
    int               waiting;

    assign fail_count = errors;
    assign pending    = waiting;

    function automatic int slot(int offset);
        return (head_pos + offset) % QUEUE_DEPTH;
    endfunction

    function automatic void close_gap(int pos);
        int k;
        for (k = pos; k + 1 < held; k++)
        begin
            id_store[slot(k)]  = id_store[slot(k + 1)];
            pri_store[slot(k)] = pri_store[slot(k + 1)];
        end
        tail_pos = (tail_pos + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
        held--;
    endfunction

    function automatic int most_urgent_pos();
        int best;
        int k;
        best = 0;
        for (k = 1; k < held; k++)
        begin
            if (pri_store[slot(k)] < pri_store[slot(best)])
                best = k;
        end
        return best;
    endfunction

    function automatic queue_result_t apply_op(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] tid,
                                               logic [PRI_W-1:0] tpri);
        queue_result_t r;
        int            k;
        r = '0;
        r.status = ST_DONE;
        case (fn)
            FN_ENQUEUE:
            begin
                if (held >= QUEUE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    id_store[tail_pos]  = tid;
                    pri_store[tail_pos] = tpri;
                    tail_pos = (tail_pos + 1) % QUEUE_DEPTH;
                    held++;
                end
            end
            FN_DEQUEUE:
            begin
                if (held == 0)
                    r.status = ST_MISS;
                else
                begin
                    r.id  = id_store[head_pos];
                    r.pri = pri_store[head_pos];
                    head_pos = (head_pos + 1) % QUEUE_DEPTH;
                    held--;
                end
            end
            FN_REMOVE:
            begin
                r.status = ST_MISS;
                for (k = 0; k < held; k++)
                begin
                    if (id_store[slot(k)] == tid)
                    begin
                        close_gap(k);
                        r.status = ST_DONE;
                        break;
                    end
                end
            end
            FN_PEEK, FN_TAKE:
            begin
                if (held == 0)
                    r.status = ST_MISS;
                else
                begin
                    k = most_urgent_pos();
                    r.id  = id_store[slot(k)];
                    r.pri = pri_store[slot(k)];
                    if (fn == FN_TAKE)
                        close_gap(k);
                end
            end
            default:
            begin
            end
        endcase
        r.empty = (held == 0);
        r.count = held[CNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        head_pos = 0;
        tail_pos = 0;
        held     = 0;
        errors   = 0;
        waiting  = 0;
    end

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("out_id", want.id, rsp.out_id);
                    check_field("out_priority", want.pri, rsp.out_priority);
                    check_field("is_empty", want.empty, rsp.is_empty);
                    check_field("entry_count", want.count, rsp.entry_count);
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(apply_op(req.func, req.task_id, req.task_priority));
            waiting = expected_q.size();
        end
    end

endmodule

`default_nettype wire

### sim/tb_ready_queue_priority_select_core.sv
// tb_ready_queue_priority_select_core: drives operation items into the ready queue
// under several idling phases and a long result hold-off, and gives the verdict
// depends on qps_pkg, the channel interfaces, the core and qps_result_checker
`default_nettype none

module tb_ready_queue_priority_select_core;
    import qps_pkg::*;

    localparam int                QUEUE_DEPTH   = 16;
    localparam int                PHASE_ITEMS   = 400;
    localparam int                LONG_HOLD     = 400;
    localparam int                STALL_LIMIT   = 5000;
    localparam int                DRAIN_CYCLES  = 60;
    localparam logic [FUNC_W-1:0] FN_SPARE_LO   = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI   = 3'd7;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   hold_seq;

    qps_req_if req_ch ();
    qps_rsp_if #(.CNT_W($clog2(QUEUE_DEPTH + 1))) rsp_ch ();

    ready_queue_priority_select_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    qps_result_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_seen;
        int n;
        hold_seen = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                rsp_ch.ready <= 1'b0;
                for (n = 1; n < LONG_HOLD; n++)
                    @(negedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_item(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] tid,
                             logic [PRI_W-1:0] tpri);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.func          <= fn;
        req_ch.task_id       <= tid;
        req_ch.task_priority <= tpri;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin
        int               i;
        int               phase;
        int               enq_pct;
        int               sel;
        logic [FUNC_W-1:0] fn;
        logic [ID_W-1:0]   tid;
        logic [PRI_W-1:0]  tpri;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.func          = '0;
        req_ch.task_id       = '0;
        req_ch.task_priority = '0;
        tx_idle_pct          = 0;
        rx_idle_pct          = 0;
        hold_seq             = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queue on every read, on remove and on the unused codes
        send_item(FN_DEQUEUE, 8'h00, 8'h00);
        send_item(FN_PEEK, 8'hFF, 8'hFF);
        send_item(FN_TAKE, 8'h00, 8'h00);
        send_item(FN_REMOVE, 8'h5A, 8'hA5);
        for (i = FN_SPARE_LO; i <= FN_SPARE_HI; i++)
            send_item(i[FUNC_W-1:0], 8'hFF, 8'hFF);
        // fill with a duplicate id and tied priorities, then one more enqueue, a take and a remove
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            tid  = (i == 9) ? 8'h22 : 8'(8'h11 * i);
            tpri = (i % 4 == 1) ? 8'h10 : ((i == 15) ? 8'h20 : 8'(8'hFF - 8'h11 * i));
            send_item(FN_ENQUEUE, tid, tpri);
        end
        send_item(FN_ENQUEUE, 8'hFF, 8'h00);
        send_item(FN_TAKE, 8'h00, 8'h00);
        send_item(FN_REMOVE, 8'h22, 8'h00);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
                1: begin tx_idle_pct = 79; rx_idle_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_idle_pct = 79; end
                default: begin tx_idle_pct = 30; rx_idle_pct = 30; end
            endcase
            if (phase == 0)
                hold_seq++;
            enq_pct = 70;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // swing between filling and draining so both ends are reached
                if (i % 50 == 0)
                    enq_pct = (enq_pct == 70) ? 25 : 70;
                tid  = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
                tpri = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
                if ($urandom_range(99) < enq_pct)
                    fn = FN_ENQUEUE;
                else
                begin
                    sel = $urandom_range(19);
                    if (sel < 5)
                        fn = FN_DEQUEUE;
                    else if (sel < 10)
                        fn = FN_REMOVE;
                    else if (sel < 13)
                        fn = FN_PEEK;
                    else if (sel < 18)
                        fn = FN_TAKE;
                    else
                        fn = 3'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
                end
                send_item(fn, tid, tpri);
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
